FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, idle while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds around reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tmbc_pkg.sv
// Shared constants and types of the tile map box collision block.
// Depends on nothing; used by the top level, tmbc_push and tmbc_checker.
package tmbc_pkg;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int MAX_ROWS_DEF    = 32;

  localparam int TILE_SIZE_W = 10;
  localparam int GRID_W      = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_W       = 15;

  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_SIZE    = 2'd2;

  localparam logic [GRID_W-1:0]      GRID_COLUMNS_RST = 6'd25;
  localparam logic [GRID_W-1:0]      GRID_ROWS_RST    = 6'd25;
  localparam logic [TILE_SIZE_W-1:0] TILE_SIZE_RST    = 10'd512;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int OUT_MIN = -16384;
  localparam int OUT_MAX = 16383;

  // Query geometry: box moved by the requested movement.
  typedef struct packed {
    logic signed [15:0] nl;
    logic signed [15:0] nt;
    logic [12:0]        w;
    logic [12:0]        h;
    logic signed [10:0] mx;
    logic signed [10:0] my;
  } query_t;

endpackage

FILE: rtl/tile_map_box_collision.sv
// Tile map box collision: wall map, row-major scan and push-out control.
// Depends on tmbc_pkg, tmbc_wall_mem and tmbc_push.
//
//   channel  signals                                   moves
//   in       in_valid/in_ready + action..move_y        load or query item
//   out      out_valid/out_ready + adjusted_x/y,changed one result per query
//   cfg      cfg_valid/cfg_ready + cfg_index,cfg_data  register write
//
// A load item is written straight into the map while in_ready stays high. A query
// item scans the map row-major up to and including the first hit; the scan reads
// one map bit per cycle, and the result passes through the push-out stage into the
// output registers. After reset a clearing pass writes all 2**(clog2(MAX_ROWS) +
// clog2(MAX_COLUMNS)) entries (1024 at the defaults); in_ready stays low meanwhile.
// cfg_ready is always high. A result waiting on out_ready holds the next query
// in its last cycle, so in_ready returns only once that result is taken.
module tile_map_box_collision #(
  parameter int MAX_COLUMNS = tmbc_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tmbc_pkg::MAX_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic [4:0]                            tile_column,
  input  logic [4:0]                            tile_row,
  input  logic                                  tile_is_wall,
  input  logic [13:0]                           box_left,
  input  logic [13:0]                           box_top,
  input  logic [12:0]                           box_width,
  input  logic [12:0]                           box_height,
  input  logic signed [10:0]                    move_x,
  input  logic signed [10:0]                    move_y,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [14:0]                    adjusted_x,
  output logic signed [14:0]                    adjusted_y,
  output logic                                  changed,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmbc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [tmbc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CC_W  = $clog2(MAX_COLUMNS + 1);
  localparam int CR_W  = $clog2(MAX_ROWS + 1);
  localparam int AW    = ROW_W + COL_W;
  localparam int TL_W  = COL_W + tmbc_pkg::TILE_SIZE_W;
  localparam int TR_W  = ROW_W + tmbc_pkg::TILE_SIZE_W;
  localparam int TW_MAX = (TL_W > TR_W) ? TL_W : TR_W;
  localparam int SW    = ((TW_MAX > 16) ? TW_MAX : 16) + 2;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t state;

  logic [tmbc_pkg::GRID_W-1:0]      grid_columns;
  logic [tmbc_pkg::GRID_W-1:0]      grid_rows;
  logic [tmbc_pkg::TILE_SIZE_W-1:0] tile_size;

  logic [AW-1:0]   clr_addr;
  tmbc_pkg::query_t q, q_in;
  logic [COL_W-1:0] sc_c;
  logic [ROW_W-1:0] sc_r;
  logic [TL_W-1:0]  sc_tl, rd_tl;
  logic [TR_W-1:0]  sc_tt, rd_tt;
  logic             iss_active;
  logic             rd_v;
  logic             rd_last;

  logic [CC_W-1:0]  eff_cols;
  logic [CR_W-1:0]  eff_rows;
  logic             col_last, row_last;

  logic             mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0]    mem_waddr, mem_raddr;

  logic signed [SW-1:0] nl_s, nt_s, w_s, h_s, tl_s, tt_s, ts_s;
  logic             overlap, hit_now, push_start, push_hit;

  logic signed [tmbc_pkg::OUT_W-1:0] p_adj_x, p_adj_y;
  logic             p_changed;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign eff_cols = (int'(grid_columns) < MAX_COLUMNS) ? CC_W'(grid_columns)
                                                       : CC_W'(MAX_COLUMNS);
  assign eff_rows = (int'(grid_rows) < MAX_ROWS) ? CR_W'(grid_rows) : CR_W'(MAX_ROWS);
  assign col_last = (CC_W'(sc_c) + CC_W'(1)) == eff_cols;
  assign row_last = (CR_W'(sc_r) + CR_W'(1)) == eff_rows;

  always_comb begin
    q_in.nl = $signed({2'b00, box_left}) + 16'(move_x);
    q_in.nt = $signed({2'b00, box_top}) + 16'(move_y);
    q_in.w  = box_width;
    q_in.h  = box_height;
    q_in.mx = move_x;
    q_in.my = move_y;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 1'b0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_IDLE && in_valid && action == tmbc_pkg::ACT_LOAD &&
                 int'(tile_column) < MAX_COLUMNS && int'(tile_row) < MAX_ROWS) begin
      mem_we    = 1'b1;
      mem_waddr = {ROW_W'(tile_row), COL_W'(tile_column)};
      mem_wdata = tile_is_wall;
    end
  end

  assign mem_raddr = {sc_r, sc_c};

  tmbc_wall_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    nl_s = SW'(q.nl);
    nt_s = SW'(q.nt);
    w_s  = $signed({{(SW-13){1'b0}}, q.w});
    h_s  = $signed({{(SW-13){1'b0}}, q.h});
    tl_s = $signed({{(SW-TL_W){1'b0}}, rd_tl});
    tt_s = $signed({{(SW-TR_W){1'b0}}, rd_tt});
    ts_s = $signed({{(SW-tmbc_pkg::TILE_SIZE_W){1'b0}}, tile_size});
    overlap = (q.w != '0) && (q.h != '0) && (tile_size != '0) &&
              (nl_s < tl_s + ts_s) && (tl_s < nl_s + w_s) &&
              (nt_s < tt_s + ts_s) && (tt_s < nt_s + h_s);
  end

  assign hit_now    = rd_v && mem_rdata && overlap;
  assign push_hit   = hit_now;
  assign push_start = (state == ST_SCAN) && (rd_v ? (hit_now || rd_last) : !iss_active);

  tmbc_push #(.TL_W(TL_W), .TR_W(TR_W), .SW(SW)) u_push (
    .clk     (clk),
    .start   (push_start),
    .hit     (push_hit),
    .q       (q),
    .tl      (rd_tl),
    .tt      (rd_tt),
    .ts      (tile_size),
    .adj_x   (p_adj_x),
    .adj_y   (p_adj_y),
    .changed (p_changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      iss_active   <= 1'b0;
      rd_v         <= 1'b0;
      out_valid    <= 1'b0;
      grid_columns <= tmbc_pkg::GRID_COLUMNS_RST;
      grid_rows    <= tmbc_pkg::GRID_ROWS_RST;
      tile_size    <= tmbc_pkg::TILE_SIZE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmbc_pkg::CFG_GRID_COLUMNS: grid_columns <= cfg_data[tmbc_pkg::GRID_W-1:0];
          tmbc_pkg::CFG_GRID_ROWS:    grid_rows    <= cfg_data[tmbc_pkg::GRID_W-1:0];
          tmbc_pkg::CFG_TILE_SIZE:    tile_size    <= cfg_data[tmbc_pkg::TILE_SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid && action == tmbc_pkg::ACT_QUERY) begin
            q          <= q_in;
            sc_c       <= '0;
            sc_r       <= '0;
            sc_tl      <= '0;
            sc_tt      <= '0;
            iss_active <= (eff_cols != '0) && (eff_rows != '0);
            rd_v       <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_v    <= iss_active && !push_start;
          rd_tl   <= sc_tl;
          rd_tt   <= sc_tt;
          rd_last <= col_last && row_last;
          if (push_start) begin
            iss_active <= 1'b0;
            state      <= ST_DONE;
          end else if (iss_active) begin
            if (col_last) begin
              sc_c  <= '0;
              sc_tl <= '0;
              sc_r  <= sc_r + ROW_W'(1);
              sc_tt <= sc_tt + TR_W'(tile_size);
              if (row_last) begin
                iss_active <= 1'b0;
              end
            end else begin
              sc_c  <= sc_c + COL_W'(1);
              sc_tl <= sc_tl + TL_W'(tile_size);
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            adjusted_x <= p_adj_x;
            adjusted_y <= p_adj_y;
            changed    <= p_changed;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/tmbc_wall_mem.sv
// Wall bit map: one write port, one read port with registered data.
// Depends on nothing.
module tmbc_wall_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tmbc_push.sv
// Push-out stage: corrects the movement against the hit tile and saturates.
// Depends on tmbc_pkg.
module tmbc_push #(
  parameter int TL_W = 15,
  parameter int TR_W = 15,
  parameter int SW   = 18
) (
  input  logic                                 clk,
  input  logic                                 start,
  input  logic                                 hit,
  input  tmbc_pkg::query_t                     q,
  input  logic [TL_W-1:0]                      tl,
  input  logic [TR_W-1:0]                      tt,
  input  logic [tmbc_pkg::TILE_SIZE_W-1:0]     ts,
  output logic signed [tmbc_pkg::OUT_W-1:0]    adj_x,
  output logic signed [tmbc_pkg::OUT_W-1:0]    adj_y,
  output logic                                 changed
);

  logic signed [SW-1:0] mx_s, my_s, nl_s, nt_s, w_s, h_s, tl_s, tt_s, ts_s;
  logic signed [SW-1:0] x_new, y_new, x_sat, y_sat;

  function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v < SW'(tmbc_pkg::OUT_MIN)) r = SW'(tmbc_pkg::OUT_MIN);
    else if (v > SW'(tmbc_pkg::OUT_MAX)) r = SW'(tmbc_pkg::OUT_MAX);
    return r;
  endfunction

  always_comb begin
    mx_s = SW'(q.mx);
    my_s = SW'(q.my);
    nl_s = SW'(q.nl);
    nt_s = SW'(q.nt);
    w_s  = $signed({{(SW-13){1'b0}}, q.w});
    h_s  = $signed({{(SW-13){1'b0}}, q.h});
    tl_s = $signed({{(SW-TL_W){1'b0}}, tl});
    tt_s = $signed({{(SW-TR_W){1'b0}}, tt});
    ts_s = $signed({{(SW-tmbc_pkg::TILE_SIZE_W){1'b0}}, ts});
    x_new = mx_s;
    y_new = my_s;
    if (hit) begin
      if (q.my < 0) y_new = my_s + tt_s + ts_s - nt_s;
      else if (q.my > 0) y_new = my_s - (nt_s + h_s - tt_s);
      if (q.mx < 0) x_new = mx_s + tl_s + ts_s - nl_s;
      else if (q.mx > 0) x_new = mx_s - (nl_s + w_s - tl_s);
    end
    x_sat = sat(x_new);
    y_sat = sat(y_new);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      adj_x   <= x_sat[tmbc_pkg::OUT_W-1:0];
      adj_y   <= y_sat[tmbc_pkg::OUT_W-1:0];
      changed <= hit;
    end
  end

endmodule

FILE: rtl/tmbc_checker.sv
// Port-level checks of the tile map box collision block, bound to its top level.
// Depends on tmbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tmbc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             action,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [14:0]               adjusted_x,
  input logic signed [14:0]               adjusted_y,
  input logic                             changed
);

  `ASSERT_CLK(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(adjusted_x) &&
      $stable(adjusted_y) && $stable(changed),
    "result item changed while stalled")
  `ASSERT_CLK(a_query_busy, clk, rst,
    in_valid && in_ready && action == tmbc_pkg::ACT_QUERY |=> !in_ready,
    "item taken during a scan")
  `ASSERT_CLK_ALWAYS(a_clear_blocks, clk, $fell(rst) |-> !in_ready, "item taken before map clear")
  `ASSERT_CLK_ALWAYS(a_reset_out, clk, rst |=> !out_valid, "result item shown after reset")

endmodule

bind tile_map_box_collision tmbc_checker u_tmbc_checker (.*);
